// ===== design/glu_pkg.sv =====
// Shared types, constants and the tanh node table of the gated activation unit.
package glu_pkg;

  // Number of linear segments of the tanh table over [0, 8)
  localparam int SEG = 64;
  localparam int SEG_W = $clog2(SEG + 1);

  // Fixed-point constants (Q16 / Q30)
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint E_INV_Q30 = 64'sd395007542;
  localparam logic signed [12:0] C_CUBIC = 13'sd2930;
  localparam logic signed [17:0] C_SCALE = 18'sd52290;

  typedef enum logic [1:0] {
    MODE_SWIGLU = 2'd0,
    MODE_GEGLU  = 2'd1,
    MODE_ADD    = 2'd2,
    MODE_MUL    = 2'd3
  } mode_t;

  // Control that travels with each pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef logic [16:0] node_t;
  typedef node_t node_arr_t [0:SEG];
  typedef logic signed [18:0] gate_t;

  // Shift-subtract quotient of two non-negative values, for table elaboration
  function automatic longint udiv64(longint a, longint b);
    longint q, rem;
    q = 0;
    rem = 0;
    for (int j = 62; j >= 0; j--) begin
      rem = (rem <<< 1) | ((a >>> j) & 64'sd1);
      if (rem >= b) begin
        rem = rem - b;
        q = q | (64'sd1 <<< j);
      end
    end
    return q;
  endfunction

  // Node k = tanh(8k/SEG) in unsigned Q16, from integer exp arithmetic in Q30
  function automatic node_arr_t build_nodes();
    node_arr_t nodes;
    longint tq, whole, f30, en, sum, term, e, num, den;
    int k, i;
    for (k = 0; k <= SEG; k++) begin
      tq = (longint'(k) * 64'sd1048576) / SEG;
      whole = tq >>> 16;
      f30 = (tq & 64'sd65535) <<< 14;
      en = Q30_ONE;
      sum = Q30_ONE;
      term = Q30_ONE;
      for (i = 0; i < whole; i++) begin
        en = (en * E_INV_Q30 + (Q30_ONE / 2)) >>> 30;
      end
      for (i = 1; i <= 14; i++) begin
        term = udiv64((term * f30) >>> 30, longint'(i));
        if (i[0]) sum = sum - term;
        else sum = sum + term;
      end
      e = (en * sum + (Q30_ONE / 2)) >>> 30;
      num = (Q30_ONE - e) * 64'sd65536;
      den = Q30_ONE + e;
      if (num < 0) num = 0;
      nodes[k] = 17'(udiv64(num + (den >>> 1), den));
    end
    return nodes;
  endfunction

  localparam node_arr_t TANH_NODES = build_nodes();

endpackage

// ===== design/glu_tanh_lut.sv =====
// Registered tanh table lookup with linear interpolation; returns 1 + tanh in Q16.
module glu_tanh_lut (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        sat,
  input  logic                        neg,
  input  logic [glu_pkg::SEG_W-1:0]   seg,
  input  logic [11:0]                 frac,
  output glu_pkg::gate_t              gate
);

  logic [glu_pkg::SEG_W-1:0] idx_lo;
  logic [glu_pkg::SEG_W-1:0] idx_hi;
  glu_pkg::node_t lo;
  glu_pkg::node_t hi;
  glu_pkg::node_t diff;
  glu_pkg::node_t r;
  logic [29:0] prod;
  logic signed [18:0] rs;
  glu_pkg::gate_t gate_next;

  // Node fetch; beyond the table range the last node is used
  always_comb begin
    idx_lo = sat ? glu_pkg::SEG_W'(glu_pkg::SEG) : seg;
    idx_hi = sat ? glu_pkg::SEG_W'(glu_pkg::SEG) : seg + 1'b1;
    lo = glu_pkg::TANH_NODES[idx_lo];
    hi = glu_pkg::TANH_NODES[idx_hi];
    diff = hi - lo;
    // interpolation step, rounded to nearest (12 fraction bits)
    prod = 30'(diff) * 30'(frac) + 30'd2048;
    r = lo + 17'(prod[29:12]);
    rs = signed'({2'b00, r});
    gate_next = neg ? (19'sd65536 - rs) : (19'sd65536 + rs);
  end

  always_ff @(posedge clk) begin
    if (en) gate <= gate_next;
  end

endmodule

// ===== design/glu_out_stage.sv =====
// Final rounding, mode select, saturation and output register.
module glu_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  glu_pkg::ctl_t        ctl,
  input  glu_pkg::mode_t       mode,
  input  logic signed [50:0]   prod,
  input  logic signed [31:0]   xy,
  input  logic signed [16:0]   xsum,
  output logic                 out_valid,
  output logic signed [15:0]   result_value,
  output logic                 saturated,
  output logic                 last_out
);

  logic signed [51:0] gated_rnd;
  logic signed [32:0] mul_rnd;
  logic signed [33:0] pre;
  logic signed [15:0] value_next;
  logic sat_next;

  always_comb begin
    // round to nearest, ties toward +inf
    gated_rnd = 52'(prod) + 52'sd16777216;
    mul_rnd = 33'(xy) + 33'sd128;
    unique case (mode)
      glu_pkg::MODE_SWIGLU,
      glu_pkg::MODE_GEGLU: pre = 34'($signed(gated_rnd[51:25]));
      glu_pkg::MODE_ADD:   pre = 34'(xsum);
      glu_pkg::MODE_MUL:   pre = 34'($signed(mul_rnd[32:8]));
      default:             pre = 34'(xsum);
    endcase
    // clip to Q8.8
    if (pre > 34'sd32767) begin
      value_next = 16'sh7fff;
      sat_next = 1'b1;
    end else if (pre < -34'sd32768) begin
      value_next = 16'sh8000;
      sat_next = 1'b1;
    end else begin
      value_next = pre[15:0];
      sat_next = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.valid;
    end
    if (en) begin
      result_value <= value_next;
      saturated <= sat_next;
      last_out <= ctl.last;
    end
  end

endmodule

// ===== design/glu_gated_activation_unit.sv =====
// Top level of the gated activation unit: seven-stage element pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one element pair x_value,
//   y_value (signed Q8.8) and last_in per transaction. Output channel
//   (out_valid/out_ready) returns result_value (Q8.8, saturated), the
//   saturated flag and last_out, one transaction per input, in order.
//   Configuration channel (cfg_valid/cfg_ready) writes the 2-bit mode:
//   swiglu, geglu, add, multiply. Write it only while the pipeline is empty.
//   An accepted input passes seven register stages, the first loaded at
//   the edge that accepts it, the last being the output register.
//   Throughput: one element per cycle when not stalled; every stage takes
//   a new transaction each cycle under one shared advance enable.
//   When the receiver stalls, the whole pipeline holds and in_ready drops
//   while the output register is full; nothing is lost or repeated.
//   Reset clears all valid bits and sets the mode to swiglu; the tanh
//   table is a constant, so the block is ready in the first cycle.
module glu_gated_activation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_value,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result_value,
  output logic               saturated,
  output logic               last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);

  localparam int SWP_W = 12 + glu_pkg::SEG_W;
  localparam int GEP_W = 11 + glu_pkg::SEG_W;

  glu_pkg::mode_t mode;
  logic adv;

  // stage 1
  glu_pkg::ctl_t s1_ctl;
  logic signed [31:0] s1_xy, s1_yy;
  logic signed [28:0] s1_cy;
  logic signed [16:0] s1_xsum;
  logic signed [15:0] s1_y;
  logic s1_sw_sat, s1_sw_neg;
  logic [glu_pkg::SEG_W-1:0] s1_sw_seg;
  logic [11:0] s1_sw_frac;
  // stage 2
  glu_pkg::ctl_t s2_ctl;
  logic signed [31:0] s2_xy;
  logic signed [16:0] s2_xsum;
  logic signed [15:0] s2_y;
  logic signed [60:0] s2_cube;
  glu_pkg::gate_t s2_sw_gate;
  // stage 3
  glu_pkg::ctl_t s3_ctl;
  logic signed [31:0] s3_xy;
  logic signed [16:0] s3_xsum;
  logic signed [48:0] s3_uprod;
  glu_pkg::gate_t s3_sw_gate;
  // stage 4
  glu_pkg::ctl_t s4_ctl;
  logic signed [31:0] s4_xy;
  logic signed [16:0] s4_xsum;
  glu_pkg::gate_t s4_sw_gate;
  logic s4_ge_sat, s4_ge_neg;
  logic [glu_pkg::SEG_W-1:0] s4_ge_seg;
  logic [11:0] s4_ge_frac;
  // stage 5
  glu_pkg::ctl_t s5_ctl;
  logic signed [31:0] s5_xy;
  logic signed [16:0] s5_xsum;
  glu_pkg::gate_t s5_sw_gate;
  glu_pkg::gate_t s5_ge_gate;
  // stage 6
  glu_pkg::ctl_t s6_ctl;
  logic signed [31:0] s6_xy;
  logic signed [16:0] s6_xsum;
  logic signed [50:0] s6_prod;

  // combinational helpers
  logic signed [16:0] y17;
  logic [16:0] ymag;
  logic [SWP_W-1:0] sw_p;
  logic signed [61:0] cube_rnd;
  logic signed [30:0] inner;
  logic signed [49:0] u_rnd;
  logic signed [33:0] u;
  logic [33:0] umag;
  logic [GEP_W-1:0] ge_p;
  glu_pkg::gate_t gate_sel;

  // Pipeline advances whenever the output register can take a transaction
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign cfg_ready = 1'b1;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) mode <= glu_pkg::MODE_SWIGLU;
    else if (cfg_valid) mode <= glu_pkg::mode_t'(cfg_data);
  end

  // SwiGLU table address: tanh(y/2) with y in Q8.8, i.e. 9 fraction bits
  always_comb begin
    y17 = 17'(y_value);
    ymag = (y17 < 0) ? 17'(-y17) : 17'(y17);
    sw_p = SWP_W'(ymag[11:0]) * SWP_W'(glu_pkg::SEG);
  end

  // Stage 1: products and SwiGLU table address
  always_ff @(posedge clk) begin
    if (rst) s1_ctl.valid <= 1'b0;
    else if (adv) s1_ctl.valid <= in_valid;
    if (adv) begin
      s1_ctl.last <= last_in;
      s1_xy <= x_value * y_value;
      s1_yy <= y_value * y_value;
      s1_cy <= 29'(y_value) * 29'(glu_pkg::C_CUBIC);
      s1_xsum <= 17'(x_value) + 17'(y_value);
      s1_y <= y_value;
      s1_sw_sat <= |ymag[16:12];
      s1_sw_neg <= y_value[15];
      s1_sw_seg <= (|ymag[16:12]) ? '0 : sw_p[SWP_W-1:12];
      s1_sw_frac <= (|ymag[16:12]) ? '0 : sw_p[11:0];
    end
  end

  // Stage 2: cubic term and SwiGLU gate lookup
  glu_tanh_lut u_sw_lut (
    .clk  (clk),
    .en   (adv),
    .sat  (s1_sw_sat),
    .neg  (s1_sw_neg),
    .seg  (s1_sw_seg),
    .frac (s1_sw_frac),
    .gate (s2_sw_gate)
  );

  always_ff @(posedge clk) begin
    if (rst) s2_ctl.valid <= 1'b0;
    else if (adv) s2_ctl.valid <= s1_ctl.valid;
    if (adv) begin
      s2_ctl.last <= s1_ctl.last;
      s2_xy <= s1_xy;
      s2_xsum <= s1_xsum;
      s2_y <= s1_y;
      s2_cube <= 61'(s1_yy) * 61'(s1_cy);
    end
  end

  // Stage 3: inner sum y + c*y^3, then scale
  always_comb begin
    cube_rnd = 62'(s2_cube) + 62'sd2147483648;
    inner = 31'(s2_y) + 31'($signed(cube_rnd[61:32]));
  end

  always_ff @(posedge clk) begin
    if (rst) s3_ctl.valid <= 1'b0;
    else if (adv) s3_ctl.valid <= s2_ctl.valid;
    if (adv) begin
      s3_ctl.last <= s2_ctl.last;
      s3_xy <= s2_xy;
      s3_xsum <= s2_xsum;
      s3_sw_gate <= s2_sw_gate;
      s3_uprod <= 49'(inner) * 49'(glu_pkg::C_SCALE);
    end
  end

  // Stage 4: GeGLU tanh argument in Q8 and its table address
  always_comb begin
    u_rnd = 50'(s3_uprod) + 50'sd32768;
    u = u_rnd[49:16];
    umag = (u < 0) ? 34'(-u) : 34'(u);
    ge_p = GEP_W'(umag[10:0]) * GEP_W'(glu_pkg::SEG);
  end

  always_ff @(posedge clk) begin
    if (rst) s4_ctl.valid <= 1'b0;
    else if (adv) s4_ctl.valid <= s3_ctl.valid;
    if (adv) begin
      s4_ctl.last <= s3_ctl.last;
      s4_xy <= s3_xy;
      s4_xsum <= s3_xsum;
      s4_sw_gate <= s3_sw_gate;
      s4_ge_sat <= |umag[33:11];
      s4_ge_neg <= u[33];
      s4_ge_seg <= (|umag[33:11]) ? '0 : ge_p[GEP_W-1:11];
      s4_ge_frac <= (|umag[33:11]) ? '0 : {ge_p[10:0], 1'b0};
    end
  end

  // Stage 5: GeGLU gate lookup
  glu_tanh_lut u_ge_lut (
    .clk  (clk),
    .en   (adv),
    .sat  (s4_ge_sat),
    .neg  (s4_ge_neg),
    .seg  (s4_ge_seg),
    .frac (s4_ge_frac),
    .gate (s5_ge_gate)
  );

  always_ff @(posedge clk) begin
    if (rst) s5_ctl.valid <= 1'b0;
    else if (adv) s5_ctl.valid <= s4_ctl.valid;
    if (adv) begin
      s5_ctl.last <= s4_ctl.last;
      s5_xy <= s4_xy;
      s5_xsum <= s4_xsum;
      s5_sw_gate <= s4_sw_gate;
    end
  end

  // Stage 6: x*y times the selected gate
  assign gate_sel = (mode == glu_pkg::MODE_GEGLU) ? s5_ge_gate : s5_sw_gate;

  always_ff @(posedge clk) begin
    if (rst) s6_ctl.valid <= 1'b0;
    else if (adv) s6_ctl.valid <= s5_ctl.valid;
    if (adv) begin
      s6_ctl.last <= s5_ctl.last;
      s6_xy <= s5_xy;
      s6_xsum <= s5_xsum;
      s6_prod <= 51'(s5_xy) * 51'(gate_sel);
    end
  end

  // Stage 7: rounding, saturation, output register
  glu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .ctl          (s6_ctl),
    .mode         (mode),
    .prod         (s6_prod),
    .xy           (s6_xy),
    .xsum         (s6_xsum),
    .out_valid    (out_valid),
    .result_value (result_value),
    .saturated    (saturated),
    .last_out     (last_out)
  );

  // A saturated result sits on one of the range limits
  assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (result_value == 16'sh7fff || result_value == 16'sh8000))
    else $error("saturated result not at a range limit");

  // Nothing comes out in the cycle after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // SwiGLU gate 1 + tanh stays within [0, 2] in Q16
  assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid |-> (s2_sw_gate >= 19'sd0 && s2_sw_gate <= 19'sd131072))
    else $error("swiglu gate out of range");

  // A stalled output holds the pipeline
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(s6_prod) && $stable(s6_ctl))
    else $error("pipeline moved during stall");

endmodule
